@@ rtl/core/lpec_pkg.sv @@
// Shared types and constants for the LED panel escape command parser.
// Used by lpec_parser, the core top level and the testbench.
`timescale 1ns / 1ps

package lpec_pkg;

  // Result actions
  typedef enum logic [3:0] {
    ACT_NONE       = 4'd0,
    ACT_BUF_WRITE  = 4'd1,
    ACT_LIVE_WRITE = 4'd2,
    ACT_REPLY      = 4'd3,
    ACT_NEW_MSG    = 4'd4,
    ACT_CLEAR_OUT  = 4'd5,
    ACT_RESTART    = 4'd6,
    ACT_SCROLL     = 4'd7,
    ACT_REWIND     = 4'd8
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BUF_SIZE = 2'd0,
    CFG_FILE_VER = 2'd1,
    CFG_BUF_ROM  = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] REPLY_OK  = 8'd0;
  localparam logic [7:0] REPLY_ERR = 8'd1;

  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_F   = 8'h46;
  localparam logic [7:0] CH_L   = 8'h4C;
  localparam logic [7:0] CH_S   = 8'h53;

  localparam logic [7:0] SET_RESTART = 8'd0;
  localparam logic [7:0] SET_DELAY1  = 8'd1;
  localparam logic [7:0] SET_LEAVE   = 8'd2;

  localparam logic [3:0] MODE_TEXT      = 4'd1;
  localparam logic [3:0] MODE_ANIM      = 4'd2;
  localparam logic [3:0] MODE_LIVE      = 4'd3;
  localparam logic [3:0] MODE_TEXT_LOAD = 4'd11;
  localparam logic [3:0] MODE_ANIM_LOAD = 4'd12;
  localparam logic [3:0] MODE_LIVE_LOAD = 4'd13;

  localparam logic [3:0] TEXT_HDR_BYTES = 4'd4;
  localparam logic [3:0] ANIM_HDR_BYTES = 4'd8;
  localparam logic [3:0] LIVE_HDR_BYTES = 4'd6;

  // Most results one byte can cause
  localparam int RES_MAX   = 5;
  localparam int RES_CNT_W = 3;
  typedef logic [RES_CNT_W-1:0] res_cnt_t;

  typedef struct packed {
    action_t     act;
    logic [9:0]  addr;
    logic [7:0]  data;
  } res_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] delay;
    logic [15:0] panels;
    logic [15:0] frames;
    logic        scroll;
    logic [9:0]  text_len;
  } status_t;

endpackage

@@ rtl/core/lpec_parser.sv @@
// Escape command parse state and per-byte result list builder.
// Depends on lpec_pkg; instantiated by the core top level.
`timescale 1ns / 1ps

module lpec_parser #(
  parameter int BUF_DEPTH      = 1024,
  parameter int MAX_PANELS     = 16,
  parameter int TEXT_ACK_BLOCK = 64,
  parameter int ANIM_ACK_BLOCK = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  input  logic [9:0]       buf_size,
  input  logic [15:0]      file_ver,
  input  logic             buf_rom,
  output lpec_pkg::res_t   res_list [lpec_pkg::RES_MAX],
  output lpec_pkg::res_cnt_t res_cnt,
  output lpec_pkg::status_t  status
);

  import lpec_pkg::*;

  localparam int LIM_CAP = BUF_DEPTH - 1;
  localparam int BLK_MAX = (TEXT_ACK_BLOCK > ANIM_ACK_BLOCK) ? TEXT_ACK_BLOCK : ANIM_ACK_BLOCK;
  localparam int BLK_W   = $clog2(BLK_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ESC, ST_TEXT, ST_ANIM, ST_LIVE, ST_SET
  } pstate_t;

  pstate_t         state_r, state_nxt;
  logic [3:0]      pcnt_r, pcnt_nxt;
  logic [7:0]      pb_r [8];
  logic [7:0]      pb_nxt [8];
  logic [7:0]      pb_w [8];
  logic [9:0]      widx_r, widx_nxt;
  logic [15:0]     exp_r, exp_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt, blk_inc;
  logic [2:0]      lrow_r, lrow_nxt;
  logic [15:0]     lpanel_r, lpanel_nxt, lpanel_inc;
  logic [3:0]      mode_r, mode_nxt;
  logic [15:0]     delay_r, delay_nxt;
  logic [15:0]     panels_r, panels_nxt;
  logic [15:0]     frames_r, frames_nxt;
  logic            scroll_r, scroll_nxt;
  logic [9:0]      tlen_r, tlen_nxt, tlen_inc, widx_inc;

  logic [9:0]      lim;
  logic [15:0]     p01, p23, p45, p67;
  logic [15:0]     text_len;
  logic [31:0]     prod;
  logic [34:0]     anim_len;
  logic [15:0]     anim_exp;
  logic            live_on_panel;

  res_t            list [RES_MAX];
  res_cnt_t        n;

  assign lim = ({7'd0, buf_size} > 17'(LIM_CAP)) ? 10'(LIM_CAP) : buf_size;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pb_w[i] = (pcnt_r[2:0] == 3'(i)) ? rx_byte : pb_r[i];
    end
  end

  assign p01      = {pb_w[1], pb_w[0]};
  assign p23      = {pb_w[3], pb_w[2]};
  assign p45      = {pb_w[5], pb_w[4]};
  assign p67      = {pb_w[7], pb_w[6]};
  assign text_len = (p23 > {6'd0, lim}) ? 16'd0 : p23;
  assign prod     = p23 * p45;
  assign anim_len = {prod, 3'b000};
  assign anim_exp = (buf_rom || (anim_len > {25'd0, lim})) ? 16'd0 : anim_len[15:0];
  assign blk_inc  = blk_r + 1'b1;
  assign tlen_inc = tlen_r + 1'b1;
  assign widx_inc = widx_r + 1'b1;
  assign lpanel_inc = lpanel_r + 1'b1;
  assign live_on_panel = {1'b0, lpanel_r} < 17'(MAX_PANELS);

  always_comb begin
    state_nxt  = state_r;
    pcnt_nxt   = pcnt_r;
    pb_nxt     = pb_r;
    widx_nxt   = widx_r;
    exp_nxt    = exp_r;
    blk_nxt    = blk_r;
    lrow_nxt   = lrow_r;
    lpanel_nxt = lpanel_r;
    mode_nxt   = mode_r;
    delay_nxt  = delay_r;
    panels_nxt = panels_r;
    frames_nxt = frames_r;
    scroll_nxt = scroll_r;
    tlen_nxt   = tlen_r;
    n          = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      list[i] = '{act: ACT_NONE, addr: 10'd0, data: 8'd0};
    end

    case (state_r)
      ST_IDLE: begin
        if (rx_byte == CH_ESC) state_nxt = ST_ESC;
      end
      ST_ESC: begin
        case (rx_byte)
          CH_C: begin
            list[n] = '{act: ACT_BUF_WRITE, addr: 10'd0, data: 8'd0}; n = n + 1'b1;
            list[n] = '{act: ACT_NEW_MSG, addr: 10'd0, data: 8'd0};   n = n + 1'b1;
            tlen_nxt  = 10'd0;
            state_nxt = ST_IDLE;
          end
          CH_T: begin
            mode_nxt  = MODE_TEXT_LOAD;
            state_nxt = ST_TEXT;
          end
          CH_F: begin
            mode_nxt  = MODE_ANIM_LOAD;
            state_nxt = ST_ANIM;
          end
          CH_L: begin
            mode_nxt  = MODE_LIVE_LOAD;
            state_nxt = ST_LIVE;
          end
          CH_S: state_nxt = ST_SET;
          default: state_nxt = ST_ESC;
        endcase
        pcnt_nxt = 4'd0;
        widx_nxt = 10'd0;
      end
      ST_TEXT: begin
        if (pcnt_r < TEXT_HDR_BYTES) begin
          pb_nxt   = pb_w;
          pcnt_nxt = pcnt_r + 1'b1;
          if (pcnt_nxt == TEXT_HDR_BYTES) begin
            list[n] = '{act: ACT_CLEAR_OUT, addr: 10'd0, data: 8'd0}; n = n + 1'b1;
            scroll_nxt = 1'b1;
            delay_nxt  = p01;
            tlen_nxt   = 10'd0;
            blk_nxt    = '0;
            exp_nxt    = text_len;
            if (text_len == 16'd0) begin
              list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_ERR}; n = n + 1'b1;
              mode_nxt = MODE_TEXT;
              list[n] = '{act: ACT_NEW_MSG, addr: 10'd0, data: 8'd0};    n = n + 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          list[n] = '{act: ACT_BUF_WRITE, addr: tlen_r, data: rx_byte}; n = n + 1'b1;
          tlen_nxt = tlen_inc;
          if (blk_inc >= BLK_W'(TEXT_ACK_BLOCK)) begin
            list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_OK}; n = n + 1'b1;
            blk_nxt = '0;
          end else begin
            blk_nxt = blk_inc;
          end
          if ({6'd0, tlen_inc} >= exp_r) begin
            list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_OK};    n = n + 1'b1;
            list[n] = '{act: ACT_BUF_WRITE, addr: tlen_inc, data: 8'd0}; n = n + 1'b1;
            mode_nxt = MODE_TEXT;
            list[n] = '{act: ACT_NEW_MSG, addr: 10'd0, data: 8'd0};      n = n + 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ANIM: begin
        if (pcnt_r < ANIM_HDR_BYTES) begin
          pb_nxt   = pb_w;
          pcnt_nxt = pcnt_r + 1'b1;
          if (pcnt_nxt == ANIM_HDR_BYTES) begin
            list[n] = '{act: ACT_REWIND, addr: 10'd0, data: 8'd0}; n = n + 1'b1;
            scroll_nxt = 1'b0;
            if (p01 != file_ver) begin
              list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_ERR}; n = n + 1'b1;
              mode_nxt  = MODE_ANIM;
              state_nxt = ST_IDLE;
            end else begin
              panels_nxt = p23;
              frames_nxt = p45;
              delay_nxt  = p67;
              widx_nxt   = 10'd0;
              blk_nxt    = '0;
              exp_nxt    = anim_exp;
              if (anim_exp == 16'd0) begin
                list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_ERR}; n = n + 1'b1;
                mode_nxt  = MODE_ANIM;
                state_nxt = ST_IDLE;
              end
            end
          end
        end else begin
          list[n] = '{act: ACT_BUF_WRITE, addr: widx_r, data: rx_byte}; n = n + 1'b1;
          widx_nxt = widx_inc;
          if (blk_inc >= BLK_W'(ANIM_ACK_BLOCK)) begin
            list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_OK}; n = n + 1'b1;
            blk_nxt = '0;
          end else begin
            blk_nxt = blk_inc;
          end
          if ({6'd0, widx_inc} >= exp_r) begin
            list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_OK}; n = n + 1'b1;
            mode_nxt  = MODE_ANIM;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LIVE: begin
        if (pcnt_r < LIVE_HDR_BYTES) begin
          pb_nxt   = pb_w;
          pcnt_nxt = pcnt_r + 1'b1;
          if (pcnt_nxt == LIVE_HDR_BYTES) begin
            list[n] = '{act: ACT_REWIND, addr: 10'd0, data: 8'd0}; n = n + 1'b1;
            scroll_nxt = 1'b0;
            if (p01 != file_ver) begin
              list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_ERR}; n = n + 1'b1;
              mode_nxt  = MODE_LIVE;
              state_nxt = ST_IDLE;
            end else begin
              panels_nxt = p23;
              frames_nxt = 16'd1;
              delay_nxt  = p45;
              lrow_nxt   = 3'd0;
              lpanel_nxt = 16'd0;
              if (p23 == 16'd0) begin
                mode_nxt  = MODE_LIVE;
                state_nxt = ST_IDLE;
              end
            end
          end
        end else begin
          if (live_on_panel) begin
            list[n] = '{act: ACT_LIVE_WRITE, addr: {lpanel_r[6:0], lrow_r}, data: rx_byte};
            n = n + 1'b1;
          end
          lrow_nxt = lrow_r + 1'b1;
          if (lrow_r == 3'd7) begin
            lpanel_nxt = lpanel_inc;
            if (lpanel_inc == panels_r) begin
              list[n] = '{act: ACT_REPLY, addr: 10'd0, data: REPLY_OK}; n = n + 1'b1;
              mode_nxt  = MODE_LIVE;
              state_nxt = ST_IDLE;
              list[n] = '{act: ACT_SCROLL, addr: 10'd0, data: 8'd0};    n = n + 1'b1;
            end
          end
        end
      end
      ST_SET: begin
        case (rx_byte)
          SET_RESTART: begin
            list[n] = '{act: ACT_RESTART, addr: 10'd0, data: 8'd0}; n = n + 1'b1;
            state_nxt = ST_IDLE;
          end
          SET_DELAY1: begin
            delay_nxt = 16'd1;
            state_nxt = ST_IDLE;
          end
          SET_LEAVE: state_nxt = ST_IDLE;
          default:   state_nxt = ST_SET;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (n == '0) begin
      list[0] = '{act: ACT_NONE, addr: 10'd0, data: 8'd0};
      n = res_cnt_t'(1);
    end
  end

  assign res_list = list;
  assign res_cnt  = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pcnt_r   <= 4'd0;
      for (int i = 0; i < 8; i++) pb_r[i] <= 8'd0;
      widx_r   <= 10'd0;
      exp_r    <= 16'd0;
      blk_r    <= '0;
      lrow_r   <= 3'd0;
      lpanel_r <= 16'd0;
      mode_r   <= 4'd0;
      delay_r  <= 16'd0;
      panels_r <= 16'd0;
      frames_r <= 16'd0;
      scroll_r <= 1'b0;
      tlen_r   <= 10'd0;
    end else if (step_en) begin
      state_r  <= state_nxt;
      pcnt_r   <= pcnt_nxt;
      pb_r     <= pb_nxt;
      widx_r   <= widx_nxt;
      exp_r    <= exp_nxt;
      blk_r    <= blk_nxt;
      lrow_r   <= lrow_nxt;
      lpanel_r <= lpanel_nxt;
      mode_r   <= mode_nxt;
      delay_r  <= delay_nxt;
      panels_r <= panels_nxt;
      frames_r <= frames_nxt;
      scroll_r <= scroll_nxt;
      tlen_r   <= tlen_nxt;
    end
  end

  assign status = '{mode: mode_r, delay: delay_r, panels: panels_r, frames: frames_r,
                    scroll: scroll_r, text_len: tlen_r};

endmodule

@@ rtl/core/led_panel_escape_command_parser_core.sv @@
// Top level of the LED panel escape command parser core.
// Depends on lpec_pkg and lpec_parser; holds config registers and the result queue.
`timescale 1ns / 1ps

// One received byte is taken per beat. Its whole effect on the parse state is worked
// out in the cycle it is accepted, and the one to five results it causes are loaded
// into a result queue that hands out one result per output beat. A byte with more than
// one result holds off the input until they drain; most bytes cause one, so the input
// runs at one byte per cycle while out_stall is low, and the next byte is taken in the
// same cycle as the last result of the previous one leaves. Status fields show the state
// after the byte whose results are on the output.
module led_panel_escape_command_parser_core #(
  parameter int BUF_DEPTH      = 1024,
  parameter int MAX_PANELS     = 16,
  parameter int TEXT_ACK_BLOCK = 64,
  parameter int ANIM_ACK_BLOCK = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_action,
  output logic [9:0]  out_addr,
  output logic [7:0]  out_data,
  output logic [3:0]  out_panel_mode,
  output logic [15:0] out_frame_delay,
  output logic [15:0] out_panel_count,
  output logic [15:0] out_frame_count,
  output logic        out_scrolling,
  output logic [9:0]  out_text_length,
  output logic        out_last
);

  import lpec_pkg::*;

  logic [9:0]  buf_size_r;
  logic [15:0] file_ver_r;
  logic        buf_rom_r;

  res_t        res_list [RES_MAX];
  res_cnt_t    res_cnt;
  status_t     status;

  res_t        list_r   [RES_MAX];
  res_t        list_nxt [RES_MAX];
  res_cnt_t    cnt_r, cnt_nxt;
  logic        acc, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= 10'd1023;
      file_ver_r <= 16'd1;
      buf_rom_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BUF_SIZE: buf_size_r <= cfg_wdata[9:0];
        CFG_FILE_VER: file_ver_r <= cfg_wdata;
        CFG_BUF_ROM:  buf_rom_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  lpec_parser #(
    .BUF_DEPTH      (BUF_DEPTH),
    .MAX_PANELS     (MAX_PANELS),
    .TEXT_ACK_BLOCK (TEXT_ACK_BLOCK),
    .ANIM_ACK_BLOCK (ANIM_ACK_BLOCK)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (acc),
    .rx_byte  (in_rx_byte),
    .buf_size (buf_size_r),
    .file_ver (file_ver_r),
    .buf_rom  (buf_rom_r),
    .res_list (res_list),
    .res_cnt  (res_cnt),
    .status   (status)
  );

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (cnt_r > res_cnt_t'(1)) || ((cnt_r == res_cnt_t'(1)) && out_stall);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    list_nxt = list_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      list_nxt = res_list;
      cnt_nxt  = res_cnt;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) list_nxt[i] = list_r[i+1];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r <= list_nxt;
  end

  assign out_action      = list_r[0].act;
  assign out_addr        = list_r[0].addr;
  assign out_data        = list_r[0].data;
  assign out_last        = (cnt_r == res_cnt_t'(1));
  assign out_panel_mode  = status.mode;
  assign out_frame_delay = status.delay;
  assign out_panel_count = status.panels;
  assign out_frame_count = status.frames;
  assign out_scrolling   = status.scroll;
  assign out_text_length = status.text_len;

endmodule

@@ rtl/core/lpec_checker.sv @@
// Port-level checks for the LED panel escape command parser core.
// Sees only the top-level ports; attached to the core by the bind below.
`timescale 1ns / 1ps

module lpec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_action,
  input logic [9:0]  out_addr,
  input logic [7:0]  out_data,
  input logic [3:0]  out_panel_mode,
  input logic [9:0]  out_text_length,
  input logic        out_last
);

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) && $stable(out_addr)
      && $stable(out_data))
    else $error("stalled result beat changed");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted byte produced no result");

  a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid)
    else $error("result list ended before last beat");

  a_status_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> $stable(out_panel_mode) && $stable(out_text_length))
    else $error("status changed within one byte's results");

endmodule

bind led_panel_escape_command_parser_core lpec_checker u_lpec_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_action      (out_action),
  .out_addr        (out_addr),
  .out_data        (out_data),
  .out_panel_mode  (out_panel_mode),
  .out_text_length (out_text_length),
  .out_last        (out_last)
);

@@ dv/tb.sv @@
// Testbench for led_panel_escape_command_parser_core: random byte streams of escape commands.
// Holds its own parser predictor and result scoreboard; uses lpec_pkg for types and codes.
`timescale 1ns / 1ps

module tb;
  import lpec_pkg::*;

  localparam int          WATCHDOG_LIMIT   = 1000;
  localparam int          HOLD_CYCLES      = 60;
  localparam logic [6:0]  TEXT_BLOCK       = 7'd64;
  localparam logic [6:0]  ANIM_BLOCK       = 7'd8;
  localparam logic [15:0] LIVE_PANEL_LIMIT = 16'd16;

  typedef enum logic [2:0] {PS_IDLE, PS_ESC, PS_TEXT, PS_ANIM, PS_LIVE, PS_SET} parse_st_t;

  typedef struct packed {
    res_t    r;
    status_t s;
    logic    last;
  } result_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_action;
  logic [9:0]  out_addr;
  logic [7:0]  out_data;
  logic [3:0]  out_panel_mode;
  logic [15:0] out_frame_delay;
  logic [15:0] out_panel_count;
  logic [15:0] out_frame_count;
  logic        out_scrolling;
  logic [9:0]  out_text_length;
  logic        out_last;

  led_panel_escape_command_parser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_addr        (out_addr),
    .out_data        (out_data),
    .out_panel_mode  (out_panel_mode),
    .out_frame_delay (out_frame_delay),
    .out_panel_count (out_panel_count),
    .out_frame_count (out_frame_count),
    .out_scrolling   (out_scrolling),
    .out_text_length (out_text_length),
    .out_last        (out_last)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Predictor state and register copies
  parse_st_t   ps = PS_IDLE;
  logic [3:0]  hdr_cnt = '0;
  logic [7:0]  hdr [8];
  logic [9:0]  wr_idx = '0;
  logic [15:0] exp_len = '0;
  logic [6:0]  blk_cnt = '0;
  logic [3:0]  row = '0;
  logic [15:0] live_pnl = '0;
  status_t     st = '0;
  res_t        step_res [$];
  logic [9:0]  buf_size_r = 10'd1023;
  logic [15:0] file_ver_r = 16'd1;
  logic        buf_rom_r = 1'b0;

  result_beat_t pending_results [$];
  logic [7:0]   rx_bytes_q [$];

  int errors = 0;
  int bytes_sent = 0;
  int beats_checked = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit jitter_on = 1'b1;

  function automatic logic [15:0] hdr_word(int lo);
    return {hdr[lo+1], hdr[lo]};
  endfunction

  function automatic void add_result(action_t a, logic [9:0] ad, logic [7:0] d);
    res_t r;
    r.act = a;
    r.addr = ad;
    r.data = d;
    step_res.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    longint unsigned len;
    result_beat_t beat;
    step_res.delete();
    case (ps)
      PS_IDLE: if (b == CH_ESC) ps = PS_ESC;
      PS_ESC: begin
        case (b)
          CH_C: begin
            add_result(ACT_BUF_WRITE, 10'd0, 8'd0);
            st.text_len = '0;
            add_result(ACT_NEW_MSG, 10'd0, 8'd0);
            ps = PS_IDLE;
          end
          CH_T: begin
            st.mode = MODE_TEXT_LOAD;
            ps = PS_TEXT;
          end
          CH_F: begin
            st.mode = MODE_ANIM_LOAD;
            ps = PS_ANIM;
          end
          CH_L: begin
            st.mode = MODE_LIVE_LOAD;
            ps = PS_LIVE;
          end
          CH_S: ps = PS_SET;
          default: ;
        endcase
        hdr_cnt = '0;
        wr_idx = '0;
      end
      PS_TEXT: if (hdr_cnt < TEXT_HDR_BYTES) begin
        hdr[hdr_cnt[2:0]] = b;
        hdr_cnt++;
        if (hdr_cnt == TEXT_HDR_BYTES) begin
          len = hdr_word(2);
          add_result(ACT_CLEAR_OUT, 10'd0, 8'd0);
          st.scroll = 1'b1;
          st.delay = hdr_word(0);
          st.text_len = '0;
          blk_cnt = '0;
          if (len > buf_size_r) len = 0;
          exp_len = 16'(len);
          if (len == 0) begin
            add_result(ACT_REPLY, 10'd0, REPLY_ERR);
            st.mode = MODE_TEXT;
            add_result(ACT_NEW_MSG, 10'd0, 8'd0);
            ps = PS_IDLE;
          end
        end
      end else begin
        add_result(ACT_BUF_WRITE, st.text_len, b);
        st.text_len++;
        blk_cnt++;
        if (blk_cnt >= TEXT_BLOCK) begin
          add_result(ACT_REPLY, 10'd0, REPLY_OK);
          blk_cnt = '0;
        end
        if ({6'd0, st.text_len} >= exp_len) begin
          add_result(ACT_REPLY, 10'd0, REPLY_OK);
          add_result(ACT_BUF_WRITE, st.text_len, 8'd0);
          st.mode = MODE_TEXT;
          add_result(ACT_NEW_MSG, 10'd0, 8'd0);
          ps = PS_IDLE;
        end
      end
      PS_ANIM: if (hdr_cnt < ANIM_HDR_BYTES) begin
        hdr[hdr_cnt[2:0]] = b;
        hdr_cnt++;
        if (hdr_cnt == ANIM_HDR_BYTES) begin
          add_result(ACT_REWIND, 10'd0, 8'd0);
          st.scroll = 1'b0;
          if (hdr_word(0) != file_ver_r) begin
            add_result(ACT_REPLY, 10'd0, REPLY_ERR);
            st.mode = MODE_ANIM;
            ps = PS_IDLE;
          end else begin
            st.panels = hdr_word(2);
            st.frames = hdr_word(4);
            st.delay = hdr_word(6);
            len = st.panels * 64'd8 * st.frames;
            wr_idx = '0;
            blk_cnt = '0;
            if (buf_rom_r || len > buf_size_r) len = 0;
            exp_len = 16'(len);
            if (len == 0) begin
              add_result(ACT_REPLY, 10'd0, REPLY_ERR);
              st.mode = MODE_ANIM;
              ps = PS_IDLE;
            end
          end
        end
      end else begin
        add_result(ACT_BUF_WRITE, wr_idx, b);
        wr_idx++;
        blk_cnt++;
        if (blk_cnt >= ANIM_BLOCK) begin
          add_result(ACT_REPLY, 10'd0, REPLY_OK);
          blk_cnt = '0;
        end
        if ({6'd0, wr_idx} >= exp_len) begin
          add_result(ACT_REPLY, 10'd0, REPLY_OK);
          st.mode = MODE_ANIM;
          ps = PS_IDLE;
        end
      end
      PS_LIVE: if (hdr_cnt < LIVE_HDR_BYTES) begin
        hdr[hdr_cnt[2:0]] = b;
        hdr_cnt++;
        if (hdr_cnt == LIVE_HDR_BYTES) begin
          add_result(ACT_REWIND, 10'd0, 8'd0);
          st.scroll = 1'b0;
          if (hdr_word(0) != file_ver_r) begin
            add_result(ACT_REPLY, 10'd0, REPLY_ERR);
            st.mode = MODE_LIVE;
            ps = PS_IDLE;
          end else begin
            st.panels = hdr_word(2);
            st.frames = 16'd1;
            st.delay = hdr_word(4);
            row = '0;
            live_pnl = '0;
            if (st.panels == 16'd0) begin
              st.mode = MODE_LIVE;
              ps = PS_IDLE;
            end
          end
        end
      end else begin
        if (live_pnl < LIVE_PANEL_LIMIT) begin
          add_result(ACT_LIVE_WRITE, {live_pnl[6:0], row[2:0]}, b);
        end
        row++;
        if (row >= 4'd8) begin
          row = '0;
          live_pnl++;
          if (live_pnl == st.panels) begin
            add_result(ACT_REPLY, 10'd0, REPLY_OK);
            st.mode = MODE_LIVE;
            ps = PS_IDLE;
            add_result(ACT_SCROLL, 10'd0, 8'd0);
          end
        end
      end
      PS_SET: begin
        case (b)
          SET_RESTART: begin
            add_result(ACT_RESTART, 10'd0, 8'd0);
            ps = PS_IDLE;
          end
          SET_DELAY1: begin
            st.delay = 16'd1;
            ps = PS_IDLE;
          end
          SET_LEAVE: ps = PS_IDLE;
          default: ;
        endcase
      end
      default: ps = PS_IDLE;
    endcase
    if (step_res.size() == 0) add_result(ACT_NONE, 10'd0, 8'd0);
    foreach (step_res[i]) begin
      beat.r = step_res[i];
      beat.s = st;
      beat.last = (i == step_res.size() - 1);
      pending_results.push_back(beat);
    end
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // Driver: hold the beat while stalled, otherwise advance from the byte queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left = $urandom_range(0, 2);
        end else if (rx_bytes_q.size() > 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat expected none actual action %0h", $time, out_action);
        end else begin
          want = pending_results.pop_front();
          check_field("action", want.r.act, out_action);
          check_field("addr", want.r.addr, out_addr);
          check_field("data", want.r.data, out_data);
          check_field("panel_mode", want.s.mode, out_panel_mode);
          check_field("frame_delay", want.s.delay, out_frame_delay);
          check_field("panel_count", want.s.panels, out_panel_count);
          check_field("frame_count", want.s.frames, out_frame_count);
          check_field("scrolling", want.s.scroll, out_scrolling);
          check_field("text_length", want.s.text_len, out_text_length);
          check_field("last", want.last, out_last);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push(logic [7:0] b);
    rx_bytes_q.push_back(b);
  endtask

  task automatic send_word(logic [15:0] w);
    push(w[7:0]);
    push(w[15:8]);
  endtask

  task automatic send_text(logic [15:0] len);
    push(CH_ESC);
    push(CH_T);
    send_word(16'($urandom));
    send_word(len);
    if (len != 0 && len <= buf_size_r) repeat (len) push(8'($urandom));
  endtask

  task automatic send_anim(logic [15:0] ver, logic [15:0] panels, logic [15:0] frames);
    longint unsigned n;
    n = panels * 64'd8 * frames;
    push(CH_ESC);
    push(CH_F);
    send_word(ver);
    send_word(panels);
    send_word(frames);
    send_word(16'($urandom));
    if (ver == file_ver_r && !buf_rom_r && n != 0 && n <= buf_size_r) begin
      repeat (n) push(8'($urandom));
    end
  endtask

  task automatic send_live(logic [15:0] ver, logic [15:0] panels);
    push(CH_ESC);
    push(CH_L);
    send_word(ver);
    send_word(panels);
    send_word(16'($urandom));
    if (ver == file_ver_r) repeat (panels * 8) push(8'($urandom));
  endtask

  task automatic send_random_command();
    int pick;
    logic [15:0] ver;
    pick = $urandom_range(0, 19);
    ver = ($urandom_range(0, 5) == 0) ? 16'($urandom) : file_ver_r;
    if (pick < 5) begin
      send_text(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)));
    end else if (pick < 10) begin
      if ($urandom_range(0, 7) == 0) send_anim(ver, 16'($urandom), 16'($urandom));
      else send_anim(ver, 16'($urandom_range(0, 2)), 16'($urandom_range(0, 3)));
    end else if (pick < 13) begin
      send_live(ver, 16'($urandom_range(0, 2)));
    end else if (pick < 15) begin
      push(CH_ESC);
      push(CH_S);
      if ($urandom_range(0, 1) == 1) push(8'($urandom_range(3, 255)));
      push(8'($urandom_range(0, 2)));
    end else if (pick < 16) begin
      push(CH_ESC);
      push(CH_C);
    end else begin
      case ($urandom_range(0, 2))
        0: push(8'($urandom));
        1: begin
          push(CH_ESC);
          push(8'($urandom));
        end
        default: begin
          push(CH_ESC);
          push(CH_F);
          repeat (3) push(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BUF_SIZE: buf_size_r = val[9:0];
      CFG_FILE_VER: file_ver_r = val;
      CFG_BUF_ROM:  buf_rom_r = val[0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push(8'hFF);
    push(CH_ESC);
    push(8'h51);
    push(CH_C);
    push(CH_ESC);
    push(CH_S);
    push(8'h80);
    push(SET_RESTART);
    push(CH_ESC);
    push(CH_S);
    push(SET_DELAY1);
    send_text(16'd0);
    send_text(16'd1);

    // Fill the block while the output is held off; panels past the limit are dropped
    send_live(file_ver_r, 16'd17);
    @(negedge clk);
    hold_req = 1'b1;
    repeat (2) send_random_command();

    write_reg(CFG_BUF_SIZE, 16'd16);
    write_reg(CFG_FILE_VER, 16'hFFFF);
    send_anim(file_ver_r, 16'd2, 16'd1);
    send_anim(file_ver_r, 16'd1, 16'd3);
    send_text(16'd16);
    send_text(16'd17);
    repeat (2) send_random_command();

    write_reg(CFG_BUF_SIZE, 16'd0);
    write_reg(CFG_FILE_VER, 16'h1234);
    write_reg(CFG_BUF_ROM, 16'd1);
    send_anim(file_ver_r, 16'd1, 16'd1);
    repeat (2) send_random_command();

    wait_drained();
    jitter_on = 1'b0;
    write_reg(CFG_BUF_SIZE, 16'd1023);
    write_reg(CFG_FILE_VER, 16'd0);
    write_reg(CFG_BUF_ROM, 16'd0);
    send_text(16'd64);
    send_live(file_ver_r, 16'd0);
    repeat (2) send_random_command();

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d result beats from %0d bytes over four register settings,",
             beats_checked, bytes_sent);
    $display("with text, animation, live, setting and noise sequences and an output hold-off.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
